FILE: src/mpps_pkg.sv
package mpps_pkg;

  localparam int DATA_W = 32;
  localparam int NUM_W  = 36;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_GUESS  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MEAN_X = 2'd1;
  localparam logic [IDX_W-1:0] REG_MEAN_Y = 2'd2;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_CAND,
    B_ICPT0,
    B_ICPT1,
    B_SCAN,
    B_DRAIN,
    B_EVAL
  } back_state_t;

  typedef enum logic {
    OUT_FREE,
    OUT_WAIT
  } fin_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      return -32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

FILE: src/mpps_ram.sv
module mpps_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mpps_queue.sv
module mpps_queue #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;

  assign empty    = (cnt == 2'd0);
  assign full     = (cnt == 2'd2);
  assign pop_data = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      slot[wp] <= push_data;
    end
  end

endmodule

FILE: src/mpps_front.sv
module mpps_front #(
  parameter int MAX_POINTS = 4096,
  parameter int CW         = $clog2(MAX_POINTS + 1),
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,
  input  logic          s_tlast,
  input  logic          back_busy,
  input  logic          q_empty,
  output logic          q_push,
  output logic [CW-1:0] q_count,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [63:0]   wr_data
);

  logic [CW-1:0] count;
  logic          accept;
  logic          room;

  assign s_tready = q_empty && !back_busy;
  assign accept   = s_tvalid && s_tready;
  assign room     = (count < CW'(MAX_POINTS));
  assign wr_en    = accept && room;
  assign wr_addr  = count[AW-1:0];
  assign wr_data  = {s_tdata[31:0], s_tdata[63:32]};
  assign q_push   = accept && s_tlast;
  assign q_count  = room ? count + CW'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + CW'(1);
    end
  end

endmodule

FILE: src/mpps_back.sv
module mpps_back #(
  parameter int SWEEP_STEPS = 64,
  parameter int MAX_POINTS  = 4096,
  parameter int CW          = $clog2(MAX_POINTS + 1),
  parameter int AW          = $clog2(MAX_POINTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  logic [CW-1:0]       job_count,
  output logic                job_pop,
  input  logic signed [31:0]  guess,
  input  logic signed [31:0]  mean_x,
  input  logic signed [31:0]  mean_y,
  output logic [AW-1:0]       rd_addr,
  input  logic [63:0]         rd_data,
  output logic                busy,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [95:0]         m_tdata
);

  localparam int JW = $clog2(SWEEP_STEPS);
  localparam int LG = $clog2(SWEEP_STEPS);
  localparam int SH = mpps_pkg::NUM_W + LG;
  localparam logic [63:0] RECIP_W =
    ((64'd1 << SH) + 64'(SWEEP_STEPS) - 64'd1) / 64'(SWEEP_STEPS);
  localparam logic [mpps_pkg::NUM_W:0] RECIP = RECIP_W[mpps_pkg::NUM_W:0];

  mpps_pkg::back_state_t state, state_next;
  mpps_pkg::fin_state_t  fin, fin_next;

  logic [2:0]                  pass_num;
  logic signed [31:0]          saved_step;
  logic                        kind_a;
  logic signed [33:0]          start_v;
  logic [mpps_pkg::NUM_W-1:0]  num;
  logic [72:0]                 acc;
  logic [2:0]                  div_cnt;
  logic signed [43:0]          cand;
  logic signed [31:0]          step;
  logic [JW-1:0]               j;
  logic signed [31:0]          slope_cur;
  logic signed [63:0]          prod_m;
  logic signed [31:0]          icpt;
  logic [CW-1:0]               count;
  logic [CW-1:0]               rd_cnt;
  logic                        v1;
  logic                        v2;
  logic signed [63:0]          prod_x;
  logic signed [31:0]          y_d;
  logic                        first;
  logic signed [42:0]          hi;
  logic signed [42:0]          lo;
  logic signed [31:0]          prev_slope;
  logic signed [31:0]          prev_icpt;
  logic [31:0]                 prev_spread;
  logic                        done;
  logic                        out_load;

  logic [2:0]                  p_inc;
  logic                        ka;
  logic signed [33:0]          st;
  logic [33:0]                 abs_st;
  logic [31:0]                 abs_sv;
  logic [17:0]                 mul_a;
  logic [18:0]                 mul_b;
  logic [36:0]                 pp;
  logic [72:0]                 pp_sh;
  logic [72:0]                 q_full;
  logic signed [47:0]          mag_s;
  logic signed [31:0]          step_v;
  logic signed [43:0]          diff;
  logic [31:0]                 spread_cur;
  logic                        stop;
  logic signed [63:0]          r_full;
  logic signed [42:0]          r;
  logic signed [31:0]          rd_x;
  logic signed [31:0]          rd_y;

  assign rd_x    = rd_data[63:32];
  assign rd_y    = rd_data[31:0];
  assign rd_addr = rd_cnt[AW-1:0];

  always_comb begin
    p_inc  = (pass_num < 3'd6) ? pass_num + 3'd1 : pass_num;
    ka     = (p_inc == 3'd1) || (p_inc == 3'd4);
    st     = ka ? -34'(guess) : 34'(guess) - 34'(saved_step);
    abs_st = st[33] ? 34'(-st) : 34'(st);
    abs_sv = saved_step[31] ? 32'(-saved_step) : 32'(saved_step);
    mul_a  = div_cnt[0] ? num[35:18] : num[17:0];
    mul_b  = div_cnt[1] ? 19'(RECIP[36:19]) : RECIP[18:0];
    pp     = 37'(mul_a) * 37'(mul_b);
    case (div_cnt[1:0])
      2'd0:    pp_sh = 73'(pp);
      2'd1:    pp_sh = 73'(pp) << 18;
      2'd2:    pp_sh = 73'(pp) << 19;
      default: pp_sh = 73'(pp) << 37;
    endcase
    q_full = acc >> SH;
    mag_s  = 48'(q_full[33:0]);
    step_v = mpps_pkg::sat32(((kind_a && !start_v[33]) || (!kind_a && start_v[33])) ?
                             -mag_s : mag_s);
    diff   = 44'(hi) - 44'(lo);
    spread_cur = (diff[43:32] != 12'd0) ? 32'hFFFF_FFFF : diff[31:0];
    stop   = ((j != '0) && (spread_cur >= prev_spread)) || (j == JW'(SWEEP_STEPS - 1));
    r_full = 64'(y_d) - ((prod_x >>> 24) + 64'(icpt));
    r      = r_full[42:0];
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    done       = 1'b0;
    unique case (state)
      mpps_pkg::B_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = mpps_pkg::B_DIV;
        end
      end
      mpps_pkg::B_DIV: begin
        if (div_cnt == 3'd4) begin
          state_next = mpps_pkg::B_CAND;
        end
      end
      mpps_pkg::B_CAND:  state_next = mpps_pkg::B_ICPT0;
      mpps_pkg::B_ICPT0: state_next = mpps_pkg::B_ICPT1;
      mpps_pkg::B_ICPT1: state_next = mpps_pkg::B_SCAN;
      mpps_pkg::B_SCAN: begin
        if (rd_cnt == count - CW'(1)) begin
          state_next = mpps_pkg::B_DRAIN;
        end
      end
      mpps_pkg::B_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = mpps_pkg::B_EVAL;
        end
      end
      mpps_pkg::B_EVAL: begin
        if (stop) begin
          done       = 1'b1;
          state_next = mpps_pkg::B_IDLE;
        end else begin
          state_next = mpps_pkg::B_CAND;
        end
      end
      default: state_next = mpps_pkg::B_IDLE;
    endcase
  end

  assign busy = (state != mpps_pkg::B_IDLE) || (fin == mpps_pkg::OUT_WAIT);

  always_comb begin
    fin_next = fin;
    out_load = 1'b0;
    unique case (fin)
      mpps_pkg::OUT_FREE: begin
        if (done) begin
          if (!m_tvalid || m_tready) begin
            out_load = 1'b1;
          end else begin
            fin_next = mpps_pkg::OUT_WAIT;
          end
        end
      end
      mpps_pkg::OUT_WAIT: begin
        if (m_tready) begin
          out_load = 1'b1;
          fin_next = mpps_pkg::OUT_FREE;
        end
      end
      default: fin_next = mpps_pkg::OUT_FREE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpps_pkg::B_IDLE;
      fin   <= mpps_pkg::OUT_FREE;
    end else begin
      state <= state_next;
      fin   <= fin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_num   <= 3'd0;
      saved_step <= '0;
      m_tvalid   <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      v1 <= (state == mpps_pkg::B_SCAN);
      v2 <= v1;
      if (job_pop) begin
        pass_num <= p_inc;
      end
      if ((state == mpps_pkg::B_DIV) && (state_next == mpps_pkg::B_CAND) &&
          ((pass_num == 3'd1) || (pass_num == 3'd2) ||
           (pass_num == 3'd4) || (pass_num == 3'd5))) begin
        saved_step <= step_v;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_x <= slope_cur * rd_x;
    y_d    <= rd_y;
    if (job_pop) begin
      count   <= job_count;
      kind_a  <= ka;
      start_v <= st;
      num     <= ka ? {abs_st, 2'b00} : mpps_pkg::NUM_W'({abs_sv, 1'b0});
      acc     <= '0;
      div_cnt <= '0;
    end
    if (state == mpps_pkg::B_DIV) begin
      if (div_cnt != 3'd4) begin
        acc     <= acc + pp_sh;
        div_cnt <= div_cnt + 3'd1;
      end
      if (state_next == mpps_pkg::B_CAND) begin
        step <= step_v;
        cand <= 44'(start_v);
        j    <= '0;
      end
    end
    if (state == mpps_pkg::B_CAND) begin
      slope_cur <= mpps_pkg::sat32(48'(cand));
      rd_cnt    <= '0;
    end
    if (state == mpps_pkg::B_ICPT0) begin
      prod_m <= slope_cur * mean_x;
    end
    if (state == mpps_pkg::B_ICPT1) begin
      icpt  <= mpps_pkg::sat32(48'(64'(mean_y) - (prod_m >>> 24)));
      first <= 1'b1;
    end
    if (state == mpps_pkg::B_SCAN) begin
      rd_cnt <= rd_cnt + CW'(1);
    end
    if (v2) begin
      first <= 1'b0;
      if (first || (r > hi)) begin
        hi <= r;
      end
      if (first || (r < lo)) begin
        lo <= r;
      end
    end
    if ((state == mpps_pkg::B_EVAL) && !stop) begin
      prev_slope  <= slope_cur;
      prev_icpt   <= icpt;
      prev_spread <= spread_cur;
      j           <= j + JW'(1);
      cand        <= cand + 44'(step);
    end
    if (out_load) begin
      m_tdata <= {prev_spread, prev_icpt, prev_slope};
    end
  end

endmodule

FILE: src/min_peak_to_peak_slope_search.sv
// channel  direction  handshake          payload
// s        in         s_tvalid/s_tready  s_tdata: point_x, point_y; s_tlast: last_point
// m        out        m_tvalid/m_tready  m_tdata: best_slope, best_intercept, min_spread
// cfg      in         cfg_we             cfg_index, cfg_data
//
// Points load one per cycle, while s_tready is high, into the point memory until s_tlast.
// The sweep then forms the step by reciprocal multiply and evaluates up to
// SWEEP_STEPS candidate slopes, each by a scan of the point memory through
// its single read port.
// Reset is synchronous; no clearing pass. s_tready drops while a sweep reads
// the memory; a result waiting on m_tready also holds off the next set.
module min_peak_to_peak_slope_search #(
  parameter int SWEEP_STEPS = 64,
  parameter int MAX_POINTS  = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [mpps_pkg::IDX_W-1:0] cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [63:0]                s_tdata,   // point_x, point_y
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [95:0]                m_tdata    // best_slope, best_intercept, min_spread
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);

  logic signed [31:0] guess;
  logic signed [31:0] mean_x;
  logic signed [31:0] mean_y;

  logic          busy;
  logic          q_empty;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic [CW-1:0] q_in;
  logic [CW-1:0] q_out;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      guess  <= '0;
      mean_x <= '0;
      mean_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpps_pkg::REG_GUESS:  guess  <= cfg_data;
        mpps_pkg::REG_MEAN_X: mean_x <= cfg_data;
        mpps_pkg::REG_MEAN_Y: mean_y <= cfg_data;
        default: ;
      endcase
    end
  end

  mpps_front #(.MAX_POINTS(MAX_POINTS), .CW(CW), .AW(AW)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .back_busy(busy), .q_empty(q_empty), .q_push(q_push), .q_count(q_in),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  mpps_queue #(.W(CW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_in),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty), .full(q_full)
  );

  mpps_ram #(.W(64), .DEPTH(MAX_POINTS), .AW(AW)) u_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd_data)
  );

  mpps_back #(.SWEEP_STEPS(SWEEP_STEPS), .MAX_POINTS(MAX_POINTS), .CW(CW), .AW(AW)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(!q_empty), .job_count(q_out), .job_pop(q_pop),
    .guess(guess), .mean_x(mean_x), .mean_y(mean_y),
    .rd_addr(rd_addr), .rd_data(rd_data), .busy(busy),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

`ifndef SYNTHESIS
  a_no_load_in_sweep: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("point request taken during sweep");
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("job queue overflow");
  a_sweep_from_pop: assert property (@(posedge clk) disable iff (rst)
    ($rose(busy) && !$past(rst)) |-> $past(q_pop)) else $error("sweep started without job");
`endif

endmodule
